@@ sv/priority_bitmap_tick_scheduler_assert.svh @@
// Assertion macros shared by the scheduler RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef PRIORITY_BITMAP_TICK_SCHEDULER_ASSERT_SVH
`define PRIORITY_BITMAP_TICK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every edge outside reset.
`define PBTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define PBTS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define PBTS_ASSERT(lbl, prop, msg)
`define PBTS_ASSERT_NEXT(lbl, trig, prop, msg)
`endif

`endif

@@ sv/pbts_pkg.sv @@
// Types and constants for the priority bitmap tick scheduler.
// Used by pbts_cell and priority_bitmap_tick_scheduler; no dependencies.
package pbts_pkg;

  localparam int NUM_PRIO = 32;
  localparam int PRIO_W   = 5;
  localparam int MASK_W   = 32;
  localparam int TIME_W   = 32;
  localparam int TICKS_W  = 16;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_DELAY = 2'd1;
  localparam logic [1:0] REQ_READY = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PRIO_W-1:0]  task_priority;
    logic [TICKS_W-1:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic [PRIO_W-1:0] next_priority;
    logic              none_ready;
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] delayed_mask;
  } rsp_t;

  // Scan token walking the cell chain, lowest priority first.
  typedef struct packed {
    logic              active;
    logic              do_wake;
    logic              wrap;
    logic [TIME_W-1:0] now;
    logic              found;
    logic [PRIO_W-1:0] best;
  } tok_t;

  // Update broadcast to the cells at request transfer.
  typedef struct packed {
    logic              en;
    logic              delay;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] wake;
    logic              epoch;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_DONE
  } state_t;

endpackage

@@ sv/priority_bitmap_tick_scheduler.sv @@
// Every request type runs one scan; one scan token walks the row of 32 priority cells,
// one cell per cycle, and the result waits until the output register is free.
// A request is taken only when no scan is in flight; a new one is taken while the previous
// response still waits in the output register.
// Reset (rst, synchronous): masks, tick counter, epoch flags and suspend bit clear.
// Depends on pbts_pkg, pbts_cell and priority_bitmap_tick_scheduler_assert.svh.
`include "priority_bitmap_tick_scheduler_assert.svh"

module priority_bitmap_tick_scheduler import pbts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  state_t              state;
  state_t              state_next;
  logic                tick_suspended;
  logic [TIME_W-1:0]   tick_time;
  logic [TIME_W-1:0]   tick_time_next;
  tok_t                head;
  tok_t                head_next;
  tok_t                tail;
  tok_t                tok [NUM_PRIO+1];
  wr_t                 wr;
  logic                req_xfer;
  logic                load;
  logic [TIME_W:0]     wake_sum;
  logic [NUM_PRIO-1:0] ready_vec;
  logic [NUM_PRIO-1:0] delayed_vec;

  assign req_xfer = req_valid && req_ready;
  assign wake_sum = {1'b0, tick_time} + (TIME_W+1)'(req.delay_ticks);

  always_comb begin
    tick_time_next    = tick_time;
    head_next         = '0;
    head_next.active  = 1'b1;
    head_next.now     = tick_time;
    wr                = '0;
    wr.prio           = req.task_priority;
    wr.wake           = wake_sum[TIME_W-1:0];
    wr.epoch          = wake_sum[TIME_W];
    case (req.req_type)
      REQ_TICK: begin
        if (!tick_suspended) begin
          tick_time_next    = tick_time + TIME_W'(1);
          head_next.do_wake = 1'b1;
          head_next.wrap    = (tick_time_next == '0);
          head_next.now     = tick_time_next;
        end
      end
      REQ_DELAY: begin
        wr.en    = req_xfer && ({1'b0, req.task_priority} < (PRIO_W+1)'(NUM_PRIO));
        wr.delay = 1'b1;
      end
      REQ_READY: begin
        wr.en = req_xfer && ({1'b0, req.task_priority} < (PRIO_W+1)'(NUM_PRIO));
      end
      default: begin
        // unused code: scan only
      end
    endcase
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_WAVE;
        end
      end
      ST_WAVE: begin
        if (tok[NUM_PRIO].active) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the finished scan until the output register frees up
        if (!rsp_valid || rsp_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_suspended <= 1'b0;
      tick_time      <= '0;
      head           <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tick_suspended <= cfg_wdata;
      end
      if (req_xfer) begin
        tick_time <= tick_time_next;
        head      <= head_next;
      end else begin
        head <= '0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAVE && tok[NUM_PRIO].active) begin
      tail <= tok[NUM_PRIO];
    end
    if (load) begin
      rsp.next_priority <= tail.found ? tail.best : '0;
      rsp.none_ready    <= !tail.found;
      rsp.ready_mask    <= MASK_W'(ready_vec);
      rsp.delayed_mask  <= MASK_W'(delayed_vec);
    end
  end

  assign tok[0] = head;

  for (genvar i = 0; i < NUM_PRIO; i++) begin : g_cell
    pbts_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (PRIO_W'(i)),
      .wr          (wr),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1]),
      .ready_bit   (ready_vec[i]),
      .delayed_bit (delayed_vec[i])
    );
  end

  `PBTS_ASSERT_NEXT(a_xfer_starts_wave, req_xfer, state == ST_WAVE && head.active,
                    "request transfer did not launch a scan")
  `PBTS_ASSERT(a_no_overlap, !(req_xfer && (tok[NUM_PRIO].active || head.active)),
               "request taken while a scan is in flight")
  `PBTS_ASSERT(a_top_is_ready,
               !(rsp_valid && !rsp.none_ready) || rsp.ready_mask[rsp.next_priority],
               "next_priority not set in ready_mask")
  `PBTS_ASSERT(a_none_empty,
               !(rsp_valid && rsp.none_ready) ||
               (rsp.ready_mask == '0 && rsp.next_priority == '0),
               "none_ready with nonzero mask or priority")

endmodule

@@ sv/pbts_cell.sv @@
// One priority slot: ready/delayed bits, wake time and next-epoch flag.
// Depends on pbts_pkg; chained by priority_bitmap_tick_scheduler.
module pbts_cell import pbts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PRIO_W-1:0] idx,
  input  wr_t               wr,
  input  tok_t              tok_in,
  output tok_t              tok_out,
  output logic              ready_bit,
  output logic              delayed_bit
);

  logic              ready;
  logic              delayed;
  logic              next_epoch;
  logic [TIME_W-1:0] wake_time;
  logic              sel;
  logic              epoch_eff;
  logic              hit;
  logic              ready_after;
  tok_t              tok_next;

  assign sel = wr.en && (wr.prio == idx);

  always_comb begin
    // a counter wrap moves every pending next-epoch wake into the current epoch
    epoch_eff   = (tok_in.active && tok_in.wrap) ? 1'b0 : next_epoch;
    hit         = tok_in.active && tok_in.do_wake && delayed && !epoch_eff &&
                  (tok_in.now >= wake_time);
    ready_after = ready || hit;
    tok_next    = tok_in;
    if (tok_in.active && ready_after) begin
      tok_next.found = 1'b1;
      tok_next.best  = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready      <= 1'b0;
      delayed    <= 1'b0;
      next_epoch <= 1'b0;
      tok_out    <= '0;
    end else begin
      tok_out <= tok_next;
      if (sel) begin
        if (wr.delay) begin
          next_epoch <= wr.epoch;
          delayed    <= 1'b1;
          ready      <= 1'b0;
        end else begin
          ready <= 1'b1;
        end
      end else if (tok_in.active) begin
        next_epoch <= epoch_eff;
        if (hit) begin
          delayed <= 1'b0;
          ready   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.delay) begin
      wake_time <= wr.wake;
    end
  end

  assign ready_bit   = ready;
  assign delayed_bit = delayed;

endmodule
